/* sv/layer_pixel_blend_core_macros.svh */
// ----------------------------------------------------------------------------
// layer_pixel_blend_core_macros
// Assertion macros shared by the layer pixel blend RTL.
// ----------------------------------------------------------------------------
`ifndef LAYER_PIXEL_BLEND_CORE_MACROS_SVH
`define LAYER_PIXEL_BLEND_CORE_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define LPB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("layer_pixel_blend_core: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define LPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("layer_pixel_blend_core: next-cycle check failed");

`else

`define LPB_ASSERT_SAME(label, ante, cons)
`define LPB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/lpb_pkg.sv */
// ----------------------------------------------------------------------------
// lpb_pkg
// Types, codes and divide-by-255 helpers for the layer pixel blend core.
// ----------------------------------------------------------------------------
package lpb_pkg;

  // blend mode register codes
  typedef enum logic [2:0] {
    MODE_REPLACE       = 3'd0,
    MODE_REPLACE_ALPHA = 3'd1,
    MODE_AVERAGE       = 3'd2,
    MODE_MIN           = 3'd3,
    MODE_MAX           = 3'd4,
    MODE_ADD           = 3'd5,
    MODE_SUBTRACT      = 3'd6,
    MODE_CENTER        = 3'd7
  } blend_mode_t;

  // destination factor codes
  localparam logic [1:0] FACTOR_UNITY      = 2'd0;
  localparam logic [1:0] FACTOR_MASK       = 2'd1;
  localparam logic [1:0] FACTOR_DEST_ALPHA = 2'd2;

  // register indexes
  localparam logic CFG_BLEND_MODE    = 1'b0;
  localparam logic CFG_FACTOR_SOURCE = 1'b1;

  // center mode pivot
  localparam logic [9:0] CENTER_PIVOT = 10'd128;

  // ceil(2^23 / 255): estimate is exact or one too large for 24-bit inputs
  localparam logic [39:0] RECIP_255 = 40'd32897;

  // first guess of n / 255
  function automatic logic [16:0] div255_est(input logic [23:0] n);
    logic [39:0] prod;
    prod = {16'd0, n} * RECIP_255;
    return prod[39:23];
  endfunction

  // drop the guess by one when it overshoots
  function automatic logic [16:0] div255_fix(input logic [16:0] q0, input logic [23:0] n);
    logic [24:0] back;
    back = {q0, 8'd0} - {8'd0, q0};
    if (back > {1'b0, n}) begin
      return q0 - 17'd1;
    end
    return q0;
  endfunction

endpackage

/* sv/layer_pixel_blend_core.sv */
// Output: result_value is driven from a register.
// Throughput: one sample per cycle; the seven-stage pipeline advances as one unit
// and halts only while a finished result waits on out_ready.
// Reset: rst (synchronous, active high) empties the pipeline and clears both
// configuration registers to replace mode with unity factor.
// ----------------------------------------------------------------------------
// layer_pixel_blend_core
// Per-sample layer compositor: blends a source plane sample onto a destination
// sample under the selected mode and factor, clipped to 0..255.
// ----------------------------------------------------------------------------
`include "layer_pixel_blend_core_macros.svh"

module layer_pixel_blend_core (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] dest_value,
  input  logic [7:0] src_value,
  input  logic [7:0] src_alpha,
  input  logic [7:0] mask_value,
  input  logic [7:0] dest_alpha_value,
  input  logic       alpha_plane,
  input  logic       src_inside,
  // output channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] result_value
);

  // configuration registers
  lpb_pkg::blend_mode_t blend_mode;
  logic [1:0]           factor_source;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode    <= lpb_pkg::MODE_REPLACE;
      factor_source <= lpb_pkg::FACTOR_UNITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpb_pkg::CFG_BLEND_MODE:    blend_mode    <= lpb_pkg::blend_mode_t'(cfg_data);
        lpb_pkg::CFG_FACTOR_SOURCE: factor_source <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances when the output register is free
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage valid bits
  logic v1, v2, v3, v4, v5, v6;

  // stage 1: captured sample and selected factor
  logic [7:0]           d1, s1, a1, m1;
  lpb_pkg::blend_mode_t mode1;
  logic                 ap1, in1;
  logic [7:0]           m_sel;

  // destination factor select
  always_comb begin
    m_sel = 8'd255;
    if (factor_source == lpb_pkg::FACTOR_MASK) begin
      m_sel = mask_value;
    end else if (factor_source == lpb_pkg::FACTOR_DEST_ALPHA &&
                 blend_mode == lpb_pkg::MODE_REPLACE_ALPHA) begin
      m_sel = dest_alpha_value;
    end
  end

  // stage 2: single-factor numerator, alpha times factor, direct results
  logic [7:0]         d2, s2;
  logic [15:0]        am2;
  logic signed [18:0] lin2;
  logic               wide2, avg2, byp2;
  logic [7:0]         bval2;

  logic signed [18:0] x_ext, m_ext, xm;
  logic [15:0]        d255;
  logic signed [9:0]  ctr;
  logic [7:0]         ctr_clip;
  logic               wide_c, avg_c, byp_c;
  logic [7:0]         bval_c;

  // center mode offset, clipped
  always_comb begin
    if (s1[7]) begin
      ctr = signed'({2'b00, d1}) + signed'({2'b00, s1}) - signed'(lpb_pkg::CENTER_PIVOT);
    end else begin
      ctr = signed'({2'b00, d1}) - signed'({2'b00, s1});
    end
    if (ctr < 0) begin
      ctr_clip = 8'd0;
    end else if (ctr > 10'sd255) begin
      ctr_clip = 8'd255;
    end else begin
      ctr_clip = ctr[7:0];
    end
  end

  // mode decode: source term sign and which results skip the divider
  always_comb begin
    x_ext  = signed'({11'd0, s1}) - signed'({11'd0, d1});
    wide_c = 1'b0;
    avg_c  = 1'b0;
    byp_c  = 1'b0;
    bval_c = d1;
    unique case (mode1)
      lpb_pkg::MODE_REPLACE: begin
        wide_c = 1'b1;
      end
      lpb_pkg::MODE_AVERAGE: begin
        wide_c = 1'b1;
        avg_c  = 1'b1;
      end
      lpb_pkg::MODE_REPLACE_ALPHA: begin
        if (ap1) begin
          byp_c  = 1'b1;
          bval_c = (s1 > d1) ? s1 : d1;
        end else if (m1 == 8'd0) begin
          byp_c  = 1'b1;
          bval_c = s1;
        end
      end
      lpb_pkg::MODE_MIN: begin
        byp_c = (d1 < s1);
      end
      lpb_pkg::MODE_MAX: begin
        byp_c = (d1 > s1);
      end
      lpb_pkg::MODE_ADD: begin
        x_ext = signed'({11'd0, s1});
      end
      lpb_pkg::MODE_SUBTRACT: begin
        x_ext = -signed'({11'd0, s1});
      end
      lpb_pkg::MODE_CENTER: begin
        byp_c  = 1'b1;
        bval_c = ctr_clip;
      end
      default: ;
    endcase
    if (!in1) begin
      byp_c  = 1'b1;
      bval_c = d1;
    end
  end

  // d*255 + x*m for the single-factor modes
  always_comb begin
    m_ext = signed'({11'd0, m1});
    xm    = x_ext * m_ext;
    d255  = {8'd0, d1} * 16'd255;
  end

  // stage 3: full numerator, clamped at zero
  logic [23:0]        n3;
  logic               wide3, byp3;
  logic [7:0]         bval3;

  logic signed [26:0] op_ext, am_ext, prod3, base3, num3;

  always_comb begin
    if (avg2) begin
      op_ext = signed'({19'd0, s2}) - signed'({19'd0, d2});
      base3  = signed'({19'd0, d2} * 27'd65025);
    end else begin
      op_ext = signed'({19'd0, s2});
      base3  = '0;
    end
    am_ext = signed'({11'd0, am2});
    prod3  = op_ext * am_ext;
    num3   = wide2 ? (base3 + prod3) : 27'(lin2);
  end

  // stage 4: quotient guess
  logic [23:0] n4;
  logic [16:0] q04;
  logic        wide4, byp4;
  logic [7:0]  bval4;

  // stage 5: exact n / 255
  logic [23:0] n5;
  logic [16:0] q15;
  logic        wide5, byp5;
  logic [7:0]  bval5;

  // stage 6: guess of second division for the two-factor modes
  logic [16:0] q16, e6;
  logic        wide6, byp6;
  logic [7:0]  bval6;

  // output select and clip
  logic [16:0] q_fin;
  logic [7:0]  res_next;

  always_comb begin
    q_fin = wide6 ? lpb_pkg::div255_fix(e6, {7'd0, q16}) : q16;
    if (byp6) begin
      res_next = bval6;
    end else if (q_fin > 17'd255) begin
      res_next = 8'd255;
    end else begin
      res_next = q_fin[7:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      d1    <= dest_value;
      s1    <= src_value;
      a1    <= src_alpha;
      m1    <= m_sel;
      mode1 <= blend_mode;
      ap1   <= alpha_plane;
      in1   <= src_inside;
      // stage 2
      d2    <= d1;
      s2    <= s1;
      am2   <= {8'd0, a1} * {8'd0, m1};
      lin2  <= xm + signed'({3'd0, d255});
      wide2 <= wide_c;
      avg2  <= avg_c;
      byp2  <= byp_c;
      bval2 <= bval_c;
      // stage 3
      n3    <= num3[26] ? 24'd0 : num3[23:0];
      wide3 <= wide2;
      byp3  <= byp2;
      bval3 <= bval2;
      // stage 4
      n4    <= n3;
      q04   <= lpb_pkg::div255_est(n3);
      wide4 <= wide3;
      byp4  <= byp3;
      bval4 <= bval3;
      // stage 5
      n5    <= n4;
      q15   <= lpb_pkg::div255_fix(q04, n4);
      wide5 <= wide4;
      byp5  <= byp4;
      bval5 <= bval4;
      // stage 6
      q16   <= q15;
      e6    <= lpb_pkg::div255_est({7'd0, q15});
      wide6 <= wide5;
      byp6  <= byp5;
      bval6 <= bval5;
      // output register
      result_value <= res_next;
    end
  end

  // an input transfer always lands in stage 1
  `LPB_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v1)
  // the first divider gives the exact quotient
  `LPB_ASSERT_SAME(a_div_exact, v5, (25'(q15) * 25'd255 <= {1'b0, n5}) && ({1'b0, n5} < 25'(q15) * 25'd255 + 25'd255))
  // a stall freezes the mid pipeline
  `LPB_ASSERT_NEXT(a_stall_holds, !en && v3, v3 && $stable(n3))
  // the last stage always reaches the output register when it moves
  `LPB_ASSERT_NEXT(a_last_to_out, en && v6, out_valid)

endmodule

/* tb/layer_pixel_blend_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// layer_pixel_blend_checker
// Tracks the configuration writes of the blend core, predicts the blended
// sample for every input transfer and compares each output transfer in order.
// ----------------------------------------------------------------------------
module layer_pixel_blend_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] dest_value,
  input  logic [7:0] src_value,
  input  logic [7:0] src_alpha,
  input  logic [7:0] mask_value,
  input  logic [7:0] dest_alpha_value,
  input  logic       alpha_plane,
  input  logic       src_inside,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] result_value,
  output int         fail_count,
  output int         pending
);

  lpb_pkg::blend_mode_t mode_copy;
  logic [1:0]           factor_copy;
  logic [7:0]           blended_q[$];
  logic [7:0]           predicted;
  logic [7:0]           want;

  // exact quotient truncated toward zero, then clipped to a byte
  function automatic logic [7:0] clip_quotient(input int num, input int den);
    int q;
    if (num <= 0) return 8'd0;
    q = num / den;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // blended sample for one input under the given mode and factor source
  function automatic logic [7:0] blend_sample(
    input lpb_pkg::blend_mode_t mode,
    input logic [1:0]           factor,
    input logic [7:0]           d_byte,
    input logic [7:0]           s_byte,
    input logic [7:0]           a_byte,
    input logic [7:0]           m_byte,
    input logic [7:0]           da_byte,
    input logic                 plane,
    input logic                 in_src
  );
    int d;
    int s;
    int a;
    int f;
    int pivot;
    logic [7:0] r;
    d = d_byte;
    s = s_byte;
    a = a_byte;
    pivot = lpb_pkg::CENTER_PIVOT;
    // dest alpha only counts as a factor in replace-alpha mode
    f = 255;
    if (factor == lpb_pkg::FACTOR_MASK) begin
      f = m_byte;
    end else if (factor == lpb_pkg::FACTOR_DEST_ALPHA &&
                 mode == lpb_pkg::MODE_REPLACE_ALPHA) begin
      f = da_byte;
    end
    if (!in_src) begin
      r = d_byte;
    end else begin
      case (mode)
        lpb_pkg::MODE_REPLACE_ALPHA: begin
          if (plane) r = (s > d) ? s_byte : d_byte;
          else if (f == 0) r = s_byte;
          else r = clip_quotient(d * 255 + (s - d) * f, 255);
        end
        lpb_pkg::MODE_AVERAGE: begin
          r = clip_quotient(d * 65025 + (s - d) * a * f, 65025);
        end
        lpb_pkg::MODE_MIN: begin
          if (d < s) r = d_byte;
          else r = clip_quotient(d * 255 - (d - s) * f, 255);
        end
        lpb_pkg::MODE_MAX: begin
          if (d > s) r = d_byte;
          else r = clip_quotient(d * 255 + (s - d) * f, 255);
        end
        lpb_pkg::MODE_ADD:      r = clip_quotient(d * 255 + s * f, 255);
        lpb_pkg::MODE_SUBTRACT: r = clip_quotient(d * 255 - s * f, 255);
        lpb_pkg::MODE_CENTER: begin
          if (s < pivot) r = clip_quotient(d - s, 1);
          else r = clip_quotient(d + (s - pivot), 1);
        end
        default:                r = clip_quotient(s * a * f, 65025);
      endcase
    end
    return r;
  endfunction

  // register copy, prediction and in-order compare
  always @(posedge clk) begin
    if (rst) begin
      mode_copy = lpb_pkg::MODE_REPLACE;
      factor_copy = lpb_pkg::FACTOR_UNITY;
      blended_q.delete();
    end else begin
      // input transfer
      if (in_valid && in_ready) begin
        predicted = blend_sample(mode_copy, factor_copy, dest_value, src_value,
                                 src_alpha, mask_value, dest_alpha_value,
                                 alpha_plane, src_inside);
        blended_q.insert(blended_q.size(), predicted);
      end
      // output transfer
      if (out_valid && out_ready) begin
        if (blended_q.size() == 0) begin
          fail_count++;
          $display("%0t: result_value %0d arrived, expected none", $time, result_value);
        end else begin
          want = blended_q.pop_front();
          if (result_value !== want) begin
            fail_count++;
            $display("%0t: result_value mismatch, expected %0d, actual %0d",
                     $time, want, result_value);
          end
        end
      end
      // config write takes effect for later transfers
      if (cfg_we) begin
        if (cfg_index == lpb_pkg::CFG_BLEND_MODE) mode_copy = lpb_pkg::blend_mode_t'(cfg_data);
        else factor_copy = cfg_data[1:0];
      end
    end
    pending = blended_q.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the layer pixel blend core with directed corner samples and random
// samples across every mode and factor source, with random gaps on both
// channels and one long output stall; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  // factor code with no meaning of its own, behaves as unity
  localparam logic [1:0] FACTOR_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 56;
  localparam int SQUEEZE_CYCLES = 150;

  typedef struct packed {
    lpb_pkg::blend_mode_t mode;
    logic [1:0]           factor;
    logic [7:0]           dest;
    logic [7:0]           src;
    logic [7:0]           alpha;
    logic [7:0]           mask;
    logic [7:0]           dest_alpha;
    logic                 plane;
    logic                 in_src;
  } sample_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [2:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] dest_value;
  logic [7:0] src_value;
  logic [7:0] src_alpha;
  logic [7:0] mask_value;
  logic [7:0] dest_alpha_value;
  logic       alpha_plane;
  logic       src_inside;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] result_value;
  int         fail_count;
  int         pending;

  logic                 send_gaps;
  logic                 recv_gaps;
  logic                 squeeze_req;
  logic                 squeeze_done;
  lpb_pkg::blend_mode_t cur_mode;
  logic [1:0]           cur_factor;
  sample_t              corner_q[$];

  layer_pixel_blend_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .dest_value       (dest_value),
    .src_value        (src_value),
    .src_alpha        (src_alpha),
    .mask_value       (mask_value),
    .dest_alpha_value (dest_alpha_value),
    .alpha_plane      (alpha_plane),
    .src_inside       (src_inside),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_value     (result_value)
  );

  layer_pixel_blend_checker chk (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .dest_value       (dest_value),
    .src_value        (src_value),
    .src_alpha        (src_alpha),
    .mask_value       (mask_value),
    .dest_alpha_value (dest_alpha_value),
    .alpha_plane      (alpha_plane),
    .src_inside       (src_inside),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_value     (result_value),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("** layer_pixel_blend_core: FAILED **");
    $finish;
  end

  // byte with extra weight on the ends and the center pivot
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = 8'd0;
      1:       b = 8'd255;
      2:       b = 8'($urandom_range(126, 130));
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  function automatic int pick_gap(input logic gaps_on);
    return gaps_on ? $urandom_range(0, 19) : 0;
  endfunction

  task automatic add_corner(input lpb_pkg::blend_mode_t mode, input logic [1:0] factor,
                            input int d, input int s, input int a, input int m,
                            input int da, input int plane, input int in_src);
    sample_t x;
    x.mode = mode;
    x.factor = factor;
    x.dest = 8'(d);
    x.src = 8'(s);
    x.alpha = 8'(a);
    x.mask = 8'(m);
    x.dest_alpha = 8'(da);
    x.plane = plane[0];
    x.in_src = in_src[0];
    corner_q.insert(corner_q.size(), x);
  endtask

  // drain the pipeline, let it settle, then write both registers
  task automatic apply_setting(input lpb_pkg::blend_mode_t mode, input logic [1:0] factor);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = lpb_pkg::CFG_BLEND_MODE;
    cfg_data = mode;
    @(negedge clk);
    cfg_index = lpb_pkg::CFG_FACTOR_SOURCE;
    cfg_data = {1'b0, factor};
    @(negedge clk);
    cfg_we = 1'b0;
    cur_mode = mode;
    cur_factor = factor;
  endtask

  // offer one sample after an optional gap and hold it until the transfer
  task automatic send_sample(input sample_t x, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    dest_value = x.dest;
    src_value = x.src;
    src_alpha = x.alpha;
    mask_value = x.mask;
    dest_alpha_value = x.dest_alpha;
    alpha_plane = x.plane;
    src_inside = x.in_src;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    squeeze_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ready = 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        squeeze_done = 1'b1;
      end
      gap = pick_gap(recv_gaps);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    sample_t x;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = lpb_pkg::CFG_BLEND_MODE;
    cfg_data = 3'd0;
    in_valid = 1'b0;
    dest_value = 8'd0;
    src_value = 8'd0;
    src_alpha = 8'd0;
    mask_value = 8'd0;
    dest_alpha_value = 8'd0;
    alpha_plane = 1'b0;
    src_inside = 1'b0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    squeeze_req = 1'b0;
    cur_mode = lpb_pkg::MODE_REPLACE;
    cur_factor = lpb_pkg::FACTOR_UNITY;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // corner samples: field extremes, each mode and the special rules
    add_corner(lpb_pkg::MODE_REPLACE, lpb_pkg::FACTOR_UNITY, 0, 255, 255, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_REPLACE, lpb_pkg::FACTOR_UNITY, 255, 255, 255, 255, 255, 1, 1);
    add_corner(lpb_pkg::MODE_REPLACE, lpb_pkg::FACTOR_MASK, 0, 255, 255, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_REPLACE_ALPHA, lpb_pkg::FACTOR_UNITY, 10, 200, 0, 0, 0, 1, 1);
    add_corner(lpb_pkg::MODE_REPLACE_ALPHA, lpb_pkg::FACTOR_UNITY, 220, 30, 0, 0, 0, 1, 1);
    add_corner(lpb_pkg::MODE_REPLACE_ALPHA, lpb_pkg::FACTOR_DEST_ALPHA,
               90, 17, 0, 255, 0, 0, 1);
    add_corner(lpb_pkg::MODE_REPLACE_ALPHA, lpb_pkg::FACTOR_DEST_ALPHA,
               90, 17, 0, 0, 128, 0, 1);
    add_corner(lpb_pkg::MODE_REPLACE_ALPHA, lpb_pkg::FACTOR_MASK, 90, 17, 0, 0, 255, 0, 1);
    add_corner(lpb_pkg::MODE_AVERAGE, lpb_pkg::FACTOR_UNITY, 255, 0, 255, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_AVERAGE, lpb_pkg::FACTOR_UNITY, 0, 255, 128, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_AVERAGE, FACTOR_SPARE, 100, 200, 200, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_MIN, lpb_pkg::FACTOR_UNITY, 40, 200, 0, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_MIN, lpb_pkg::FACTOR_MASK, 200, 40, 0, 100, 0, 0, 1);
    add_corner(lpb_pkg::MODE_MAX, lpb_pkg::FACTOR_UNITY, 200, 40, 0, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_MAX, lpb_pkg::FACTOR_MASK, 40, 200, 0, 100, 0, 0, 1);
    add_corner(lpb_pkg::MODE_ADD, lpb_pkg::FACTOR_UNITY, 200, 200, 0, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_ADD, lpb_pkg::FACTOR_DEST_ALPHA, 100, 100, 0, 0, 0, 1, 1);
    add_corner(lpb_pkg::MODE_SUBTRACT, lpb_pkg::FACTOR_UNITY, 50, 200, 0, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_SUBTRACT, lpb_pkg::FACTOR_MASK, 200, 100, 0, 128, 0, 0, 1);
    add_corner(lpb_pkg::MODE_CENTER, lpb_pkg::FACTOR_UNITY, 10, 100, 0, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_CENTER, lpb_pkg::FACTOR_UNITY, 200, 255, 0, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_CENTER, lpb_pkg::FACTOR_UNITY, 0, 0, 0, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_CENTER, lpb_pkg::FACTOR_UNITY, 77, 128, 0, 0, 0, 0, 1);
    add_corner(lpb_pkg::MODE_ADD, lpb_pkg::FACTOR_UNITY, 12, 255, 255, 255, 255, 1, 0);
    add_corner(lpb_pkg::MODE_AVERAGE, lpb_pkg::FACTOR_MASK, 0, 255, 255, 255, 255, 0, 0);

    foreach (corner_q[i]) begin
      x = corner_q[i];
      if (x.mode != cur_mode || x.factor != cur_factor) apply_setting(x.mode, x.factor);
      send_sample(x, pick_gap(send_gaps));
    end

    // random samples under every mode and factor source
    for (int m = 0; m < 8; m++) begin
      for (int f = 0; f < 4; f++) begin
        apply_setting(lpb_pkg::blend_mode_t'(m), f[1:0]);
        send_gaps = ($urandom_range(0, 3) != 0);
        recv_gaps = ($urandom_range(0, 3) != 0);
        // one phase fills the pipeline against a long output stall
        if (lpb_pkg::blend_mode_t'(m) == lpb_pkg::MODE_REPLACE_ALPHA &&
            f[1:0] == lpb_pkg::FACTOR_MASK) begin
          send_gaps = 1'b0;
          squeeze_req = 1'b1;
        end
        repeat (PHASE_ITEMS) begin
          x.mode = cur_mode;
          x.factor = cur_factor;
          x.dest = pick_byte();
          x.src = pick_byte();
          x.alpha = pick_byte();
          x.mask = pick_byte();
          x.dest_alpha = pick_byte();
          x.plane = 1'($urandom_range(0, 1));
          x.in_src = ($urandom_range(0, 7) != 0);
          send_sample(x, pick_gap(send_gaps));
        end
      end
    end
    in_valid = 1'b0;

    // drain, then a settle window past the pipeline depth
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** layer_pixel_blend_core: PASSED **");
    end else begin
      $display("** layer_pixel_blend_core: FAILED **");
    end
    $finish;
  end

endmodule
